// ===== hdl/tccf_pkg.sv =====
// ----------------------------------------------------------------------------
// tccf_pkg
// Shared types and codes for the TCP client connection state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tccf_pkg;

    localparam int unsigned NUM_W     = 32;
    localparam int unsigned FLAGS_W   = 8;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // event kinds
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECV = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OPEN = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NA      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SEQ_ERR = 2'd2;

    // flag bits
    localparam logic [FLAGS_W-1:0] FL_FIN    = 8'h01;
    localparam logic [FLAGS_W-1:0] FL_SYN    = 8'h02;
    localparam logic [FLAGS_W-1:0] FL_ACK    = 8'h10;
    localparam logic [FLAGS_W-1:0] FL_SYNACK = 8'h12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ACK = 1'b1;

    localparam logic [NUM_W-1:0] INITIAL_SEQ_RST = 32'd1234;
    localparam logic [NUM_W-1:0] INITIAL_ACK_RST = 32'd0;

    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_ESTABLISHED = 3'd2,
        ST_FIN_WAIT1   = 3'd3,
        ST_FIN_WAIT2   = 3'd4,
        ST_TIME_WAIT   = 3'd5
    } conn_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FLAGS_W-1:0] seg_flags;
        logic [NUM_W-1:0]   seg_seq;
        logic [NUM_W-1:0]   seg_ack;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [2:0]          conn_state_now;
        logic                tx_valid;
        logic [FLAGS_W-1:0]  tx_flags;
        logic [NUM_W-1:0]    tx_seq;
        logic [NUM_W-1:0]    tx_ack;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [NUM_W-1:0]     wdata;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ===== hdl/tccf_in_stage.sv =====
// ----------------------------------------------------------------------------
// tccf_in_stage
// Input register: holds one event beat until the core consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccf_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tccf_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output tccf_pkg::item_t    item
);

    logic            valid_reg;
    logic            valid_next;
    tccf_pkg::item_t item_reg;

    // register is free when empty or drained this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hdl/tccf_core.sv =====
// ----------------------------------------------------------------------------
// tccf_core
// Connection state, send/ack numbers, config registers and event decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccf_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tccf_pkg::cfg_wr_t cfg,
    input  wire tccf_pkg::item_t   item,
    input  wire logic              take,
    output tccf_pkg::result_t      result
);

    tccf_pkg::conn_state_t         state_reg, state_next;
    logic [tccf_pkg::NUM_W-1:0]    send_reg, send_next;
    logic [tccf_pkg::NUM_W-1:0]    ack_reg, ack_next;
    logic [tccf_pkg::NUM_W-1:0]    init_seq_reg, init_ack_reg;
    logic [tccf_pkg::NUM_W-1:0]    expect_ack;
    logic [tccf_pkg::NUM_W-1:0]    peer_next;
    logic                          ack_ok;

    assign expect_ack = send_reg + 32'd1;
    assign peer_next  = item.seg_seq + 32'd1;
    assign ack_ok     = (item.seg_ack == expect_ack);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_seq_reg <= tccf_pkg::INITIAL_SEQ_RST;
            init_ack_reg <= tccf_pkg::INITIAL_ACK_RST;
        end else if (cfg.wr_en) begin
            case (cfg.index)
                tccf_pkg::REG_INITIAL_SEQ: init_seq_reg <= cfg.wdata;
                tccf_pkg::REG_INITIAL_ACK: init_ack_reg <= cfg.wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tccf_pkg::ST_CLOSED;
            send_reg  <= tccf_pkg::INITIAL_SEQ_RST;
            ack_reg   <= tccf_pkg::INITIAL_ACK_RST;
        end else if (take) begin
            state_reg <= state_next;
            send_reg  <= send_next;
            ack_reg   <= ack_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        send_next  = send_reg;
        ack_next   = ack_reg;
        result     = '0;
        result.status = tccf_pkg::STAT_NA;

        case (item.cmd)
            tccf_pkg::CMD_OPEN: begin
                state_next    = tccf_pkg::ST_CLOSED;
                send_next     = init_seq_reg;
                ack_next      = init_ack_reg;
                result.status = tccf_pkg::STAT_OK;
            end
            tccf_pkg::CMD_SEND: begin
                // header always goes out with the current numbers
                result.tx_valid = 1'b1;
                result.tx_flags = item.seg_flags;
                result.tx_seq   = send_reg;
                result.tx_ack   = ack_reg;
                if (state_reg == tccf_pkg::ST_CLOSED
                    && (item.seg_flags & tccf_pkg::FL_SYN) != '0) begin
                    state_next    = tccf_pkg::ST_SYN_SENT;
                    result.status = tccf_pkg::STAT_OK;
                end else if (state_reg == tccf_pkg::ST_ESTABLISHED
                    && (item.seg_flags & tccf_pkg::FL_FIN) != '0) begin
                    state_next    = tccf_pkg::ST_FIN_WAIT1;
                    result.status = tccf_pkg::STAT_OK;
                end
            end
            tccf_pkg::CMD_RECV: begin
                case (state_reg)
                    tccf_pkg::ST_SYN_SENT: begin
                        if ((item.seg_flags & tccf_pkg::FL_SYNACK) == tccf_pkg::FL_SYNACK) begin
                            if (!ack_ok) begin
                                result.status = tccf_pkg::STAT_SEQ_ERR;
                            end else begin
                                state_next      = tccf_pkg::ST_ESTABLISHED;
                                send_next       = item.seg_ack;
                                ack_next        = peer_next;
                                result.status   = tccf_pkg::STAT_OK;
                                result.tx_valid = 1'b1;
                                result.tx_flags = tccf_pkg::FL_ACK;
                                result.tx_seq   = item.seg_ack;
                                result.tx_ack   = peer_next;
                            end
                        end
                    end
                    tccf_pkg::ST_FIN_WAIT1: begin
                        if ((item.seg_flags & tccf_pkg::FL_ACK) != '0) begin
                            if (!ack_ok) begin
                                result.status = tccf_pkg::STAT_SEQ_ERR;
                            end else begin
                                state_next    = tccf_pkg::ST_FIN_WAIT2;
                                ack_next      = peer_next;
                                result.status = tccf_pkg::STAT_OK;
                            end
                        end
                    end
                    tccf_pkg::ST_FIN_WAIT2: begin
                        if ((item.seg_flags & tccf_pkg::FL_FIN) != '0) begin
                            if (!ack_ok) begin
                                result.status = tccf_pkg::STAT_SEQ_ERR;
                            end else begin
                                state_next      = tccf_pkg::ST_TIME_WAIT;
                                send_next       = item.seg_ack;
                                ack_next        = peer_next;
                                result.status   = tccf_pkg::STAT_OK;
                                result.tx_valid = 1'b1;
                                result.tx_flags = tccf_pkg::FL_ACK;
                                result.tx_seq   = item.seg_ack;
                                result.tx_ack   = peer_next;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        result.conn_state_now = state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/tccf_out_stage.sv =====
// ----------------------------------------------------------------------------
// tccf_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccf_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire tccf_pkg::result_t result,
    output logic                   free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tccf_pkg::result_t      m_result
);

    logic              valid_reg;
    logic              valid_next;
    tccf_pkg::result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ===== hdl/tcp_client_connection_fsm.sv =====
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm
// TCP client connection tracker: one result beat per event beat.
// ----------------------------------------------------------------------------
// Input channel s_*: one event beat (cmd, seg_flags, seg_seq, seg_ack) per
// valid/ready handshake. Result channel m_*: exactly one result beat per
// event, in order: status, state after the event and an optional header.
// Config port: cfg_wr_en with cfg_index 0 (initial_seq) or 1 (initial_ack)
// and cfg_wdata, written at the clock edge; write only while idle.
// Path: an accepted event is held in the input register, then decoded with
// the state update and loaded into the result register in one pass.
// Throughput: one event per cycle with m_ready high; state/number registers
// update in one pass through the decode logic, so events follow back to back.
// Receiver stall: the result register holds its beat; the input register
// still takes one more event, after which s_ready drops until m_ready.
// Reset (aresetn low, synchronous): state closed, send number 1234, ack
// number 0, config back to those values, both channels empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_client_connection_fsm (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tccf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tccf_pkg::NUM_W-1:0]        cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [tccf_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [tccf_pkg::FLAGS_W-1:0]      s_seg_flags,
    input  wire logic [tccf_pkg::NUM_W-1:0]        s_seg_seq,
    input  wire logic [tccf_pkg::NUM_W-1:0]        s_seg_ack,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tccf_pkg::STATUS_W-1:0]          m_status,
    output logic [2:0]                             m_conn_state_now,
    output logic                                   m_tx_valid,
    output logic [tccf_pkg::FLAGS_W-1:0]           m_tx_flags,
    output logic [tccf_pkg::NUM_W-1:0]             m_tx_seq,
    output logic [tccf_pkg::NUM_W-1:0]             m_tx_ack
);

    tccf_pkg::item_t   s_item;
    tccf_pkg::item_t   item;
    tccf_pkg::cfg_wr_t cfg;
    tccf_pkg::result_t result;
    tccf_pkg::result_t m_result;
    logic              item_valid;
    logic              out_free;
    logic              take;

    assign s_item.cmd       = s_cmd;
    assign s_item.seg_flags = s_seg_flags;
    assign s_item.seg_seq   = s_seg_seq;
    assign s_item.seg_ack   = s_seg_ack;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    // an event is processed when it is held and the result slot opens
    assign take = item_valid && out_free;

    tccf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tccf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .take    (take),
        .result  (result)
    );

    tccf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_status         = m_result.status;
    assign m_conn_state_now = m_result.conn_state_now;
    assign m_tx_valid       = m_result.tx_valid;
    assign m_tx_flags       = m_result.tx_flags;
    assign m_tx_seq         = m_result.tx_seq;
    assign m_tx_ack         = m_result.tx_ack;

    // header fields are zero whenever no header goes out
    a_no_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_flags == '0 && m_tx_seq == '0 && m_tx_ack == '0)
        else $error("header fields nonzero without tx_valid");

    // a discarded segment never produces a header
    a_seq_err_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == tccf_pkg::STAT_SEQ_ERR |-> !m_tx_valid)
        else $error("header emitted on sequence error");

    // an open event lands in the result register as closed/ok
    a_open_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.cmd == tccf_pkg::CMD_OPEN |=>
            m_valid && m_conn_state_now == tccf_pkg::ST_CLOSED
            && m_status == tccf_pkg::STAT_OK)
        else $error("open event result wrong");

    // a result is only loaded into a free slot
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !take)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
